FILE: hw/rtl/stuffed_sync_frame_receiver_unit_macros.svh
// Assertion macros for the sync-byte deframer checker.
// Included by ssfr_checker.sv; depends on nothing else.
`ifndef STUFFED_SYNC_FRAME_RECEIVER_UNIT_MACROS_SVH
`define STUFFED_SYNC_FRAME_RECEIVER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define SSFR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define SSFR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ssfr_pkg.sv
// Shared types and constants for the sync-byte deframer.
// Used by every module of the block but ssfr_fifo; depends on nothing.
`default_nettype none

package ssfr_pkg;

  // Configuration register indexes
  localparam int          CFG_IDX_W         = 1;
  localparam logic [0:0]  REG_SYNC_VALUE    = 1'b0;
  localparam logic [0:0]  REG_TIMEOUT_TICKS = 1'b1;
  localparam int          CFG_DATA_W        = 16;

  // Register reset values
  localparam logic [7:0]  SYNC_VALUE_RESET    = 8'd254;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

  // Frame header length (id, size low, size high)
  localparam logic [15:0] HEADER_LEN = 16'd3;

  // Default queue depths
  localparam int QUEUE_DEPTH_DEFAULT  = 2;
  localparam int RESULT_DEPTH_DEFAULT = 2;

  // Input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Byte kinds
  localparam logic [1:0] KIND_ID      = 2'd0;
  localparam logic [1:0] KIND_SIZE_LO = 2'd1;
  localparam logic [1:0] KIND_SIZE_HI = 2'd2;
  localparam logic [1:0] KIND_PAYLOAD = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_SIZE    = 2'd2;

  // Deframer phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_ID      = 5'b00010,
    PH_SIZE_LO = 5'b00100,
    PH_SIZE_HI = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // Classified input word
  typedef struct packed {
    logic       action;
    logic [7:0] data;
    logic       is_sync;
    logic       is_zero;
  } item_t;

  // Result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       frame_last;
    logic [1:0] error_code;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssfr_fifo.sv
// Small register FIFO used for the item queue and the result queue.
// Standalone; no package dependency.
`default_nettype none

module ssfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ssfr_front.sv
// Front end: accepts input words, tags sync and zero bytes, queues them.
// Depends on ssfr_pkg and ssfr_fifo.
`default_nettype none

module ssfr_front #(
  parameter int QUEUE_DEPTH = ssfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            action,
  input  wire logic [7:0]      rx_byte,
  input  wire logic [7:0]      sync_value,
  output ssfr_pkg::item_t      item,
  output logic                 item_valid,
  input  wire logic            item_take
);

  ssfr_pkg::item_t tagged_item;
  logic            queue_empty;

  // Classify the incoming byte
  always_comb begin
    tagged_item.action  = action;
    tagged_item.data    = rx_byte;
    tagged_item.is_sync = (rx_byte == sync_value);
    tagged_item.is_zero = (rx_byte == 8'd0);
  end

  ssfr_fifo #(
    .WIDTH ($bits(ssfr_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (tagged_item),
    .full    (full),
    .rd_en   (item_take),
    .rd_data (item),
    .empty   (queue_empty)
  );

  assign item_valid = !queue_empty;

endmodule

`default_nettype wire

FILE: hw/rtl/ssfr_back.sv
// Back end: deframer state machine with stuffing removal and timeout.
// Depends on ssfr_pkg and ssfr_fifo; results leave through a small queue.
`default_nettype none

module ssfr_back #(
  parameter int RESULT_DEPTH = ssfr_pkg::RESULT_DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ssfr_pkg::item_t item,
  input  wire logic            item_valid,
  output logic                 item_take,
  input  wire logic [15:0]     timeout_ticks,
  output logic                 empty,
  input  wire logic            pop,
  output ssfr_pkg::result_t    result
);

  ssfr_pkg::phase_t  phase, phase_next;
  logic              stuff_armed, stuff_armed_next;
  logic [7:0]        size_low_byte, size_low_byte_next;
  logic [15:0]       bytes_remaining, bytes_remaining_next;
  logic [15:0]       idle_count, idle_count_next;

  logic              res_full;
  logic              res_push;
  ssfr_pkg::result_t res_word;

  logic [15:0]       idle_inc;
  logic [15:0]       size_word;
  logic [15:0]       remaining_dec;
  logic              drop;

  // Take a word whenever a result slot is free
  assign item_take = item_valid && !res_full;

  assign idle_inc      = (idle_count == 16'hFFFF) ? idle_count : idle_count + 16'd1;
  assign size_word     = {item.data, size_low_byte};
  assign remaining_dec = (bytes_remaining != 16'd0) ? bytes_remaining - 16'd1
                                                    : bytes_remaining;
  assign drop          = stuff_armed && item.is_zero;

  // Next state and result
  always_comb begin
    phase_next           = phase;
    stuff_armed_next     = stuff_armed;
    size_low_byte_next   = size_low_byte;
    bytes_remaining_next = bytes_remaining;
    idle_count_next      = idle_count;
    res_push             = 1'b0;
    res_word             = '0;

    if (item_take) begin
      if (phase == ssfr_pkg::PH_HUNT) begin
        // Hunt for the sync byte
        if (item.action == ssfr_pkg::ACT_BYTE && item.is_sync) begin
          phase_next       = ssfr_pkg::PH_ID;
          stuff_armed_next = 1'b0;
          idle_count_next  = 16'd0;
        end
      end else if (item.action == ssfr_pkg::ACT_TICK) begin
        // Count idle ticks, abort at the limit
        if (idle_inc >= timeout_ticks) begin
          phase_next           = ssfr_pkg::PH_HUNT;
          stuff_armed_next     = 1'b0;
          bytes_remaining_next = 16'd0;
          idle_count_next      = 16'd0;
          res_push             = 1'b1;
          res_word.out_byte    = 8'd0;
          res_word.byte_kind   = ssfr_pkg::KIND_ID;
          res_word.frame_last  = 1'b1;
          res_word.error_code  = ssfr_pkg::ERR_TIMEOUT;
        end else begin
          idle_count_next = idle_inc;
        end
      end else begin
        // Byte inside a frame: stuffing check, then field decode
        idle_count_next = 16'd0;
        if (stuff_armed) begin
          stuff_armed_next = 1'b0;
        end else if (item.is_sync) begin
          stuff_armed_next = 1'b1;
        end
        if (!drop) begin
          res_push            = 1'b1;
          res_word.out_byte   = item.data;
          res_word.frame_last = 1'b0;
          res_word.error_code = ssfr_pkg::ERR_NONE;
          unique case (phase)
            ssfr_pkg::PH_ID: begin
              res_word.byte_kind = ssfr_pkg::KIND_ID;
              phase_next         = ssfr_pkg::PH_SIZE_LO;
            end
            ssfr_pkg::PH_SIZE_LO: begin
              res_word.byte_kind = ssfr_pkg::KIND_SIZE_LO;
              size_low_byte_next = item.data;
              phase_next         = ssfr_pkg::PH_SIZE_HI;
            end
            ssfr_pkg::PH_SIZE_HI: begin
              res_word.byte_kind = ssfr_pkg::KIND_SIZE_HI;
              if (size_word <= ssfr_pkg::HEADER_LEN) begin
                phase_next           = ssfr_pkg::PH_HUNT;
                stuff_armed_next     = 1'b0;
                bytes_remaining_next = 16'd0;
                idle_count_next      = 16'd0;
                res_word.frame_last  = 1'b1;
                if (size_word != ssfr_pkg::HEADER_LEN) begin
                  res_word.error_code = ssfr_pkg::ERR_SIZE;
                end
              end else begin
                bytes_remaining_next = size_word - ssfr_pkg::HEADER_LEN;
                phase_next           = ssfr_pkg::PH_PAYLOAD;
              end
            end
            ssfr_pkg::PH_PAYLOAD: begin
              res_word.byte_kind = ssfr_pkg::KIND_PAYLOAD;
              if (remaining_dec == 16'd0) begin
                phase_next           = ssfr_pkg::PH_HUNT;
                stuff_armed_next     = 1'b0;
                bytes_remaining_next = 16'd0;
                idle_count_next      = 16'd0;
                res_word.frame_last  = 1'b1;
              end else begin
                bytes_remaining_next = remaining_dec;
              end
            end
            default: begin
              res_push   = 1'b0;
              phase_next = ssfr_pkg::PH_HUNT;
            end
          endcase
        end
      end
    end
  end

  // Hold deframer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ssfr_pkg::PH_HUNT;
      stuff_armed     <= 1'b0;
      size_low_byte   <= 8'd0;
      bytes_remaining <= 16'd0;
      idle_count      <= 16'd0;
    end else begin
      phase           <= phase_next;
      stuff_armed     <= stuff_armed_next;
      size_low_byte   <= size_low_byte_next;
      bytes_remaining <= bytes_remaining_next;
      idle_count      <= idle_count_next;
    end
  end

  ssfr_fifo #(
    .WIDTH ($bits(ssfr_pkg::result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_results (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/stuffed_sync_frame_receiver_unit.sv
// Sync-byte deframer with zero stuffing. Push received bytes (action 0) and
// time ticks (action 1) into the input side; pop delivered frame words from
// the result side, one per kept byte, each tagged with its kind, a
// last-of-frame mark and an error code (timeout or size below three).
// The block takes one word per clock cycle while the item queue is not full.
// A pushed word lands in the item queue (QUEUE_DEPTH entries) at the
// accepting edge, is decoded by the deframer, and its result is written
// into the result queue, from which it can be popped. The deframer
// advances only while the result queue (RESULT_DEPTH entries) has a free
// slot, so sustained rate is one word per cycle as long as results are
// popped.
// Write configuration only while the block is idle.
//
// Top level of the block; depends on ssfr_pkg, ssfr_front, ssfr_back.
`default_nettype none

module stuffed_sync_frame_receiver_unit #(
  parameter int QUEUE_DEPTH  = ssfr_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int RESULT_DEPTH = ssfr_pkg::RESULT_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [ssfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssfr_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input side
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            action,
  input  wire logic [7:0]                      rx_byte,
  // Result side
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [7:0]                           out_byte,
  output logic [1:0]                           byte_kind,
  output logic                                 frame_last,
  output logic [1:0]                           error_code
);

  logic [7:0]        sync_value;
  logic [15:0]       timeout_ticks;
  ssfr_pkg::item_t   item;
  logic              item_valid;
  logic              item_take;
  ssfr_pkg::result_t result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value    <= ssfr_pkg::SYNC_VALUE_RESET;
      timeout_ticks <= ssfr_pkg::TIMEOUT_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssfr_pkg::REG_SYNC_VALUE:    sync_value    <= cfg_data[7:0];
        ssfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ssfr_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .rx_byte    (rx_byte),
    .sync_value (sync_value),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  ssfr_back #(
    .RESULT_DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .timeout_ticks (timeout_ticks),
    .empty         (empty),
    .pop           (pop),
    .result        (result)
  );

  assign out_byte   = result.out_byte;
  assign byte_kind  = result.byte_kind;
  assign frame_last = result.frame_last;
  assign error_code = result.error_code;

endmodule

`default_nettype wire

FILE: hw/rtl/ssfr_checker.sv
// Port-level checker for the deframer, bound to the top level.
// Depends on ssfr_pkg and stuffed_sync_frame_receiver_unit_macros.svh.
`default_nettype none

`include "stuffed_sync_frame_receiver_unit_macros.svh"

module ssfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] byte_kind,
  input wire logic       frame_last,
  input wire logic [1:0] error_code
);

  // Reset drains the result side
  `SSFR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result side not empty after reset")

  // Every error word closes its frame
  `SSFR_ASSERT(a_error_last, clk, rst,
    (!empty && error_code != ssfr_pkg::ERR_NONE) |-> frame_last, "error word without frame end")

  // Timeout abort carries a zero id word
  `SSFR_ASSERT(a_timeout_word, clk, rst,
    (!empty && error_code == ssfr_pkg::ERR_TIMEOUT)
      |-> (out_byte == 8'd0 && byte_kind == ssfr_pkg::KIND_ID),
    "bad timeout word")

  // Size error is reported on the size high word
  `SSFR_ASSERT(a_size_error_kind, clk, rst,
    (!empty && error_code == ssfr_pkg::ERR_SIZE) |-> (byte_kind == ssfr_pkg::KIND_SIZE_HI),
    "size error on wrong kind")

  // A waiting result holds until popped
  `SSFR_ASSERT(a_result_hold, clk, rst,
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(byte_kind)),
    "waiting result changed")

endmodule

bind stuffed_sync_frame_receiver_unit ssfr_checker u_ssfr_checker (.*);

`default_nettype wire
